>>> rtl/b64d_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_pkg: shared types and constants of the URL-safe base64 decoder
// Holds the classified character type passed from the front stage to the
// back stage, the queue depth, the default count limit and the alphabet
// lookup function.
// ----------------------------------------------------------------------------
package b64d_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam logic [31:0] COUNT_LIMIT_DEFAULT = 32'd65535;
  localparam int unsigned COUNT_W = 16;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  // One classified character as it travels through the queue.
  typedef struct packed {
    logic       is_valid;
    logic [5:0] sextet;
    logic       eos;
  } b64d_item_t;

  typedef struct packed {
    logic       is_valid;
    logic [5:0] sextet;
  } b64d_class_t;

  // Maps one byte to its six-bit value in the URL-safe alphabet.
  function automatic b64d_class_t sextet_of(input logic [7:0] c);
    b64d_class_t r;
    logic [7:0]  d;
    r = '0;
    d = 8'h00;
    if (c >= 8'h41 && c <= 8'h5A) begin
      d = c - 8'h41;           // 'A'..'Z' -> 0..25
      r.is_valid = 1'b1;
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      d = c - 8'h47;           // 'a'..'z' -> 26..51
      r.is_valid = 1'b1;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      d = c + 8'h04;           // '0'..'9' -> 52..61
      r.is_valid = 1'b1;
    end else if (c == 8'h2D) begin
      d = 8'd62;               // '-'
      r.is_valid = 1'b1;
    end else if (c == 8'h5F) begin
      d = 8'd63;               // '_'
      r.is_valid = 1'b1;
    end
    r.sextet = d[5:0];
    return r;
  endfunction

endpackage

>>> rtl/b64d_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_front: input stage of the decoder
// Accepts one character beat, looks it up in the alphabet and holds the
// classified item in a register until the queue takes it.
// ----------------------------------------------------------------------------
module b64d_front
  import b64d_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char,
  input  logic       in_eos,
  output logic       item_valid,
  input  logic       item_ready,
  output b64d_item_t item
);

  logic        held;
  b64d_item_t  held_item;
  b64d_class_t cls;

  assign cls        = sextet_of(in_char);
  assign in_ready   = !held || item_ready;
  assign item_valid = held;
  assign item       = held_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_valid && in_ready) begin
      held <= 1'b1;
    end else if (item_ready) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_item.is_valid <= cls.is_valid;
      held_item.sextet   <= cls.sextet;
      held_item.eos      <= in_eos;
    end
  end

endmodule

>>> rtl/b64d_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_queue: short queue between the front and back stages
// A small register FIFO that can push and pop in the same cycle.
// ----------------------------------------------------------------------------
module b64d_queue
  import b64d_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push_valid,
  output logic       push_ready,
  input  b64d_item_t push_item,
  output logic       pop_valid,
  input  logic       pop_ready,
  output b64d_item_t pop_item
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  b64d_item_t       slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != FULL_CNT);
  assign pop_valid  = (count != '0);
  assign pop_item   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

>>> rtl/b64d_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_back: decode stage of the decoder
// Keeps the group position, leftover bits, halt flag and character count,
// builds one result per classified character and holds it in the output
// register.
// ----------------------------------------------------------------------------
module b64d_back
  import b64d_pkg::*;
#(
  parameter logic [31:0] COUNT_LIMIT = COUNT_LIMIT_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  b64d_item_t         item,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               has_byte,
  output logic [7:0]         out_byte,
  output logic               halted,
  output logic [COUNT_W-1:0] valid_count,
  output logic               string_done
);

  localparam logic [COUNT_W-1:0] COUNT_CAP =
    (COUNT_LIMIT > 32'(COUNT_MAX)) ? COUNT_MAX : COUNT_LIMIT[COUNT_W-1:0];

  logic [1:0]         group_pos;
  logic [5:0]         leftover;
  logic               stopped;
  logic [COUNT_W-1:0] counter;

  logic [1:0]         group_pos_next;
  logic [5:0]         leftover_next;
  logic               stopped_next;
  logic [COUNT_W-1:0] counter_next;
  logic               has_next;
  logic [7:0]         byte_next;
  logic               take;

  assign item_ready = !out_valid || out_ready;
  assign take       = item_valid && item_ready;

  always_comb begin
    group_pos_next = group_pos;
    leftover_next  = leftover;
    stopped_next   = stopped;
    counter_next   = counter;
    has_next       = 1'b0;
    byte_next      = 8'h00;
    if (!stopped) begin
      if (!item.is_valid) begin
        stopped_next = 1'b1;
      end else begin
        unique case (group_pos)
          2'd0: begin
            leftover_next = item.sextet;
          end
          2'd1: begin
            byte_next     = {leftover, item.sextet[5:4]};
            leftover_next = {2'b00, item.sextet[3:0]};
            has_next      = 1'b1;
          end
          2'd2: begin
            byte_next     = {leftover[3:0], item.sextet[5:2]};
            leftover_next = {4'b0000, item.sextet[1:0]};
            has_next      = 1'b1;
          end
          default: begin
            byte_next     = {leftover[1:0], item.sextet};
            leftover_next = 6'd0;
            has_next      = 1'b1;
          end
        endcase
        group_pos_next = group_pos + 2'd1;
        if (counter < COUNT_CAP) begin
          counter_next = counter + 1'b1;
        end
      end
    end
  end

  // Decoder state: the end flag returns everything to reset after the
  // result of that character has been formed.
  always_ff @(posedge clk) begin
    if (rst) begin
      group_pos <= 2'd0;
      leftover  <= 6'd0;
      stopped   <= 1'b0;
      counter   <= '0;
    end else if (take) begin
      if (item.eos) begin
        group_pos <= 2'd0;
        leftover  <= 6'd0;
        stopped   <= 1'b0;
        counter   <= '0;
      end else begin
        group_pos <= group_pos_next;
        leftover  <= leftover_next;
        stopped   <= stopped_next;
        counter   <= counter_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      has_byte    <= has_next;
      out_byte    <= byte_next;
      halted      <= stopped_next;
      valid_count <= counter_next;
      string_done <= item.eos;
    end
  end

endmodule

>>> rtl/base64url_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64url_decoder: streaming URL-safe base64 decoder
// Takes one encoded character per beat and returns one result beat per
// character: an optional decoded byte, the halt flag, the running count of
// valid characters and the end-of-string echo.
// ----------------------------------------------------------------------------
//
//   Channel   Dir   Payload                                  Marker
//   s_axis    in    tdata[7:0] = in_char                     tlast = end_of_string
//   m_axis    out   tdata[7:0] = out_byte,                   tlast = string_done
//                   tdata[23:8] = valid_count,
//                   tuser[0] = has_byte, tuser[1] = halted
//
// The block accepts one character beat per clock while results are taken and
// returns one result beat per character. A result beat passes the classify
// register, the two-entry queue and the decode output register before it is
// presented on m_axis.
// Reset (rst, synchronous, active high) empties the pipeline and clears the
// decoder state. Either side may stall on its own; while a result beat waits,
// the queue and the classify register hold up to three more character beats
// before the input stalls.
// ----------------------------------------------------------------------------
module base64url_decoder
  import b64d_pkg::*;
#(
  parameter logic [31:0] COUNT_LIMIT = COUNT_LIMIT_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_char
  input  logic        s_axis_tlast,   // end_of_string
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] out_byte, [23:8] valid_count
  output logic [1:0]  m_axis_tuser,   // [0] has_byte, [1] halted
  output logic        m_axis_tlast    // string_done
);

  // Front stage to queue.
  logic       front_valid;
  logic       front_ready;
  b64d_item_t front_item;

  // Queue to back stage.
  logic       queue_valid;
  logic       queue_ready;
  b64d_item_t queue_item;

  logic               res_has_byte;
  logic [7:0]         res_byte;
  logic               res_halted;
  logic [COUNT_W-1:0] res_count;
  logic               res_done;

  // Classify each character into its six-bit value and a valid flag.
  b64d_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_char    (s_axis_tdata),
    .in_eos     (s_axis_tlast),
    .item_valid (front_valid),
    .item_ready (front_ready),
    .item       (front_item)
  );

  // Decouples the classify stage from the decode stage.
  b64d_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_item  (front_item),
    .pop_valid  (queue_valid),
    .pop_ready  (queue_ready),
    .pop_item   (queue_item)
  );

  // Group tracking, byte assembly and the output register.
  b64d_back #(
    .COUNT_LIMIT (COUNT_LIMIT)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (queue_valid),
    .item_ready  (queue_ready),
    .item        (queue_item),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .has_byte    (res_has_byte),
    .out_byte    (res_byte),
    .halted      (res_halted),
    .valid_count (res_count),
    .string_done (res_done)
  );

  assign m_axis_tdata = {res_count, res_byte};
  assign m_axis_tuser = {res_halted, res_has_byte};
  assign m_axis_tlast = res_done;

endmodule
